// ===== hw/rtl/tama_pkg.sv =====
// ----------------------------------------------------------------------------
// tama_pkg
// Shared types, constants and helpers of the three-axis moving average unit.
// ----------------------------------------------------------------------------
package tama_pkg;

  localparam int unsigned NUM_AXES       = 3;
  localparam int unsigned WINDOW_MAX_DEF = 32;
  localparam int unsigned SAMPLE_W       = 6;
  localparam int unsigned DEPTH_W        = 6;
  localparam int unsigned CMD_DEPTH      = 2;
  localparam int unsigned CENTER         = 32;

  localparam logic signed [SAMPLE_W:0] CENTER_S = (SAMPLE_W+1)'(CENTER);
  localparam logic [7:0]               OFFSET   = 8'd128;

  typedef struct packed {
    logic [7:0] x_byte;
    logic [7:0] y_byte;
    logic [7:0] z_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] x_average;
    logic [7:0] y_average;
    logic [7:0] z_average;
    logic       average_valid;
    logic [7:0] sample_count;
  } out_t;

  // Work item handed from the front to the back. Lane 0 is x, 1 is y, 2 is z.
  typedef struct packed {
    logic                               bypass;
    logic [NUM_AXES-1:0][SAMPLE_W-1:0]  sample;
    logic [DEPTH_W-1:0]                 shift_depth;
    logic [DEPTH_W-1:0]                 avg_depth;
    logic [7:0]                         count;
  } cmd_t;

  // Stored entry (0..63) to its signed value (-32..31).
  function automatic logic signed [SAMPLE_W:0] centered(logic [SAMPLE_W-1:0] v);
    return signed'({1'b0, v}) - CENTER_S;
  endfunction

endpackage

// ===== hw/rtl/tama_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// tama_cmd_fifo
// Short queue of work items between the front and the back.
// ----------------------------------------------------------------------------
module tama_cmd_fifo import tama_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int unsigned PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned NW = $clog2(CMD_DEPTH + 1);

  cmd_t          entry_q [CMD_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] fill_q;
  logic          do_push, do_pop;

  assign full_o  = (fill_q == NW'(CMD_DEPTH));
  assign empty_o = (fill_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + NW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - NW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/tama_front.sv =====
// ----------------------------------------------------------------------------
// tama_front
// Holds the window register, fill level and sample counter; turns each
// accepted sample into a work item for the back end.
// ----------------------------------------------------------------------------
module tama_front import tama_pkg::*; #(
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DEPTH_W-1:0] cfg_wdata_i,
  input  logic               push_i,
  input  in_t                in_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output cmd_t               cmd_o
);

  logic [DEPTH_W-1:0] window_q;
  logic [DEPTH_W-1:0] fill_q;
  logic [7:0]         count_q;
  logic [DEPTH_W-1:0] depth;
  logic               ramp;

  // Clamp the window to the buffer size.
  assign depth = (window_q > DEPTH_W'(WINDOW_MAX)) ? DEPTH_W'(WINDOW_MAX) : window_q;
  assign ramp  = (fill_q < depth);

  always_comb begin
    cmd_o.bypass      = (window_q == '0);
    cmd_o.sample[0]   = in_data_i.x_byte[7:2];
    cmd_o.sample[1]   = in_data_i.y_byte[7:2];
    cmd_o.sample[2]   = in_data_i.z_byte[7:2];
    cmd_o.shift_depth = depth;
    cmd_o.avg_depth   = ramp ? fill_q + DEPTH_W'(1) : depth;
    cmd_o.count       = count_q + 8'd1;
  end

  assign q_push_o = push_i && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      fill_q   <= '0;
      count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (q_push_o) begin
        count_q <= count_q + 8'd1;
        if (!cmd_o.bypass && ramp) begin
          fill_q <= fill_q + DEPTH_W'(1);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/tama_back.sv =====
// ----------------------------------------------------------------------------
// tama_back
// Unless the window is zero, shifts the history memory one entry per cycle while summing the window,
// then divides the three sums in parallel and registers the result.
// ----------------------------------------------------------------------------
module tama_back import tama_pkg::*; #(
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  input  logic pop_i,
  output logic empty_o,
  output out_t out_data_o
);

  localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned SW = $clog2(CENTER * WINDOW_MAX + 1) + 1;
  localparam int unsigned MW = SW + 1;
  localparam int unsigned CW = $clog2(MW);
  localparam int unsigned WW = NUM_AXES * SAMPLE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH,
    S_PUT,
    S_DIV,
    S_RES
  } state_e;

  state_e                   state_q;
  cmd_t                     cur_q;
  logic [AW-1:0]            src_q;
  logic                     pend_q;
  logic [AW-1:0]            pend_addr_q;
  logic [WINDOW_MAX-1:0]    vld_q;
  logic signed [SW-1:0]     sum_q [NUM_AXES];
  logic [NUM_AXES-1:0]      neg_q;
  logic [MW-1:0]            quo_q [NUM_AXES];
  logic [DEPTH_W-1:0]       rem_q [NUM_AXES];
  logic [CW-1:0]            cnt_q;
  out_t                     out_q;
  logic                     out_vld_q;

  logic [WW-1:0]            mem_q [WINDOW_MAX];
  logic [WW-1:0]            rdata_q;
  logic                     rd_vld_q;

  logic                     rd_en, wr_en, acc_en;
  logic [AW-1:0]            wr_addr;
  logic [WW-1:0]            old_word, wr_data;
  logic [SW-1:0]            abs_sum [NUM_AXES];
  logic [MW-1:0]            mag [NUM_AXES];
  logic [DEPTH_W:0]         shifted [NUM_AXES];
  logic [NUM_AXES-1:0]      ge;
  logic [DEPTH_W-1:0]       rem_next [NUM_AXES];
  logic [7:0]               avg8 [NUM_AXES];

  assign cmd_pop_o   = (state_q == S_IDLE) && !cmd_empty_i;
  assign empty_o     = !out_vld_q;
  assign out_data_o  = out_q;

  // Entries never written read as zero.
  assign old_word = rd_vld_q ? rdata_q : '0;
  assign rd_en    = (state_q == S_WALK);
  assign wr_en    = pend_q || (state_q == S_PUT);
  assign wr_addr  = pend_q ? pend_addr_q + AW'(1) : '0;
  assign wr_data  = pend_q ? old_word : cur_q.sample;
  // Moved entry lands inside the averaging span.
  assign acc_en   = pend_q && (DEPTH_W'(pend_addr_q) < cur_q.avg_depth - DEPTH_W'(1));

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      abs_sum[a]  = sum_q[a][SW-1] ? SW'(-sum_q[a]) : SW'(sum_q[a]);
      mag[a]      = {abs_sum[a][SW-2:0], 2'b00};
      shifted[a]  = {rem_q[a], quo_q[a][MW-1]};
      ge[a]       = (shifted[a] >= {1'b0, cur_q.avg_depth});
      rem_next[a] = ge[a] ? DEPTH_W'(shifted[a] - {1'b0, cur_q.avg_depth})
                          : DEPTH_W'(shifted[a]);
      avg8[a]     = (neg_q[a] ? 8'd0 - quo_q[a][7:0] : quo_q[a][7:0]) + OFFSET;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q  <= mem_q[src_q];
      rd_vld_q <= vld_q[src_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      src_q       <= '0;
      vld_q       <= '0;
      cnt_q       <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (pop_i && out_vld_q) begin
        out_vld_q <= 1'b0;
      end
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (acc_en) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          sum_q[a] <= sum_q[a] + SW'(centered(old_word[a*SAMPLE_W +: SAMPLE_W]));
        end
      end
      case (state_q)
        S_IDLE: begin
          if (!cmd_empty_i) begin
            cur_q <= cmd_i;
            if (cmd_i.bypass) begin
              state_q <= S_RES;
            end else begin
              // Start each sum with the incoming sample.
              for (int a = 0; a < NUM_AXES; a++) begin
                sum_q[a] <= SW'(centered(cmd_i.sample[a]));
              end
              if (cmd_i.shift_depth > DEPTH_W'(1)) begin
                src_q   <= AW'(cmd_i.shift_depth - DEPTH_W'(2));
                state_q <= S_WALK;
              end else begin
                state_q <= S_PUT;
              end
            end
          end
        end
        S_WALK: begin
          pend_q      <= 1'b1;
          pend_addr_q <= src_q;
          if (src_q == '0) begin
            state_q <= S_FLUSH;
          end else begin
            src_q <= src_q - AW'(1);
          end
        end
        S_FLUSH: begin
          pend_q  <= 1'b0;
          state_q <= S_PUT;
        end
        S_PUT: begin
          for (int a = 0; a < NUM_AXES; a++) begin
            neg_q[a] <= sum_q[a][SW-1];
            quo_q[a] <= mag[a];
            rem_q[a] <= '0;
          end
          cnt_q   <= CW'(MW - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          for (int a = 0; a < NUM_AXES; a++) begin
            rem_q[a] <= rem_next[a];
            quo_q[a] <= {quo_q[a][MW-2:0], ge[a]};
          end
          if (cnt_q == '0) begin
            state_q <= S_RES;
          end else begin
            cnt_q <= cnt_q - CW'(1);
          end
        end
        S_RES: begin
          // Hold until the result register is free.
          if (!out_vld_q) begin
            out_q.x_average     <= cur_q.bypass ? 8'd0 : avg8[0];
            out_q.y_average     <= cur_q.bypass ? 8'd0 : avg8[1];
            out_q.z_average     <= cur_q.bypass ? 8'd0 : avg8[2];
            out_q.average_valid <= !cur_q.bypass;
            out_q.sample_count  <= cur_q.count;
            out_vld_q           <= 1'b1;
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_pend_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_WALK || state_q == S_FLUSH))
    else $error("pending history write outside the shift walk");

  a_walk_not_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || state_q == S_FLUSH) |-> !cur_q.bypass)
    else $error("history shifted for a zero-window transaction");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == '0) |=> state_q == S_RES)
    else $error("divider did not finish on its last step");

  a_res_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES && !out_vld_q) |=> (out_vld_q && state_q == S_IDLE))
    else $error("result not registered from a free result slot");

endmodule

// ===== hw/rtl/three_axis_moving_average_unit.sv =====
// ----------------------------------------------------------------------------
// three_axis_moving_average_unit
// Boxcar moving average over three accelerometer axes with a queue interface.
// ----------------------------------------------------------------------------
// Each pushed transaction carries three axis high bytes; each popped one
// carries the per-axis mean times four plus 128, a valid flag and a wrapping
// sample count. The window register (0 disables filtering) is clamped to
// WINDOW_MAX. A sample with a zero window skips the walk and the divider.
// For a filtered sample, the history memory has one read and one write
// port, so the shift-and-sum walk moves one entry per cycle, and the
// restoring divider then retires one quotient bit per cycle over
// MW = clog2(32*WINDOW_MAX+1)+2 bits (13 at the default of 32). A two-entry
// queue lets new samples be pushed while the back end works and while a
// result waits to be popped.
// History entries start at their reset value through per-entry valid bits,
// so no clearing pass follows reset.
module three_axis_moving_average_unit import tama_pkg::*; #(
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DEPTH_W-1:0] cfg_wdata_i,
  input  logic               push,
  input  in_t                in_data_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output out_t               out_data_o
);

  cmd_t front_cmd, queue_cmd;
  logic q_push, q_full, q_pop, q_empty;

  assign full = q_full;

  tama_front #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .cmd_o       (front_cmd)
  );

  tama_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (queue_cmd)
  );

  tama_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_empty_i (q_empty),
    .cmd_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for three_axis_moving_average_unit. Samples are pushed
// through the input queue under random idling. A scoreboard keeps its own
// boxcar state per axis, predicts every popped average, valid flag and sample
// count, and checks each popped transaction in order. The run walks the
// window register through zero, one, small, full, clamped and shrinking
// settings.
// ----------------------------------------------------------------------------
module tb import tama_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 4;
  localparam int LINE_DEPTH   = WINDOW_MAX_DEF;
  localparam int SETTLE       = 80;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 45;

  class average_tracker;
    bit [SAMPLE_W-1:0] history[NUM_AXES][LINE_DEPTH];
    int                fill_level;
    bit [7:0]          samples_seen;
    bit [DEPTH_W-1:0]  window;
    out_t              expected_averages[$];
    int                mismatches;

    function void load_window(bit [DEPTH_W-1:0] w);
      window = w;
    endfunction

    function int pending();
      return expected_averages.size();
    endfunction

    // Advance the delay lines and queue the average this sample must produce.
    function void note_sample(in_t s);
      out_t     r;
      bit [7:0] raw[NUM_AXES];
      bit [7:0] avg[NUM_AXES];
      int       depth;
      int       span;
      int       sum;
      int       mag;
      int       q;
      raw = '{s.x_byte, s.y_byte, s.z_byte};
      avg = '{8'd0, 8'd0, 8'd0};
      samples_seen++;
      r = '0;
      r.sample_count = samples_seen;
      depth = window;
      if (depth != 0) begin
        if (depth > LINE_DEPTH) depth = LINE_DEPTH;
        // only the newest depth-1 entries move; older ones hold
        for (int a = 0; a < NUM_AXES; a++) begin
          for (int i = depth - 1; i > 0; i--) history[a][i] = history[a][i-1];
          history[a][0] = raw[a][7:2];
        end
        if (fill_level < depth) begin
          fill_level++;
          span = fill_level;
        end else begin
          span = depth;
        end
        for (int a = 0; a < NUM_AXES; a++) begin
          sum = 0;
          for (int i = 0; i < span; i++) sum += int'(history[a][i]) - int'(CENTER);
          mag = (sum < 0 ? -sum : sum) * 4;
          q = mag / span;
          if (sum < 0) q = -q;
          avg[a] = 8'(q + 128);
        end
        r.average_valid = 1'b1;
      end
      r.x_average = avg[0];
      r.y_average = avg[1];
      r.z_average = avg[2];
      expected_averages.push_back(r);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_averages.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_averages.pop_front();
      compare_field("x_average", want.x_average, got.x_average);
      compare_field("y_average", want.y_average, got.y_average);
      compare_field("z_average", want.z_average, got.z_average);
      compare_field("average_valid", want.average_valid, got.average_valid);
      compare_field("sample_count", want.sample_count, got.sample_count);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [DEPTH_W-1:0] cfg_wdata = '0;
  logic               push = 1'b0;
  in_t                in_data = '0;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  out_t               out_data;

  average_tracker     tracker = new();
  bit                 no_idle = 1'b0;
  in_t                last_sample = '0;
  int                 cycle_count = 0;
  bit [DEPTH_W-1:0]   plan[12];

  three_axis_moving_average_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .push        (push),
    .in_data_i   (in_data),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("three_axis_moving_average_unit regression: fail");
      $finish;
    end
  end

  // Pop side: check the transaction taken at this edge, then pick the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) tracker.check_result(out_data);
    pop <= no_idle || ($urandom_range(99) >= 32);
  end

  task automatic send_sample(input in_t s);
    if (!no_idle) begin
      while ($urandom_range(99) < 32) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push    <= 1'b1;
    in_data <= s;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tracker.note_sample(s);
  endtask

  // Hold the sender until every expected average has been popped.
  task automatic drain_results();
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_window(input bit [DEPTH_W-1:0] w);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tracker.load_window(w);
  endtask

  function automatic in_t random_sample(in_t prev);
    in_t s;
    int  pick;
    s    = 24'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) begin
      // pin each axis to a rail so window sums reach their limits
      s.x_byte[7:2] = $urandom_range(1) ? 6'h3f : 6'h00;
      s.y_byte[7:2] = $urandom_range(1) ? 6'h3f : 6'h00;
      s.z_byte[7:2] = $urandom_range(1) ? 6'h3f : 6'h00;
    end else if (pick < 30) begin
      s.x_byte[7:2] = prev.x_byte[7:2];
      s.y_byte[7:2] = prev.y_byte[7:2];
      s.z_byte[7:2] = prev.z_byte[7:2];
    end
    return s;
  endfunction

  task automatic run_random(input int count);
    repeat (count) begin
      last_sample = random_sample(last_sample);
      send_sample(last_sample);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // window zero out of reset: no averaging, count still advances
    send_sample(in_t'{8'h00, 8'hff, 8'h80});
    send_sample(in_t'{8'hff, 8'h00, 8'h7f});
    send_sample(in_t'{8'hfc, 8'h03, 8'h40});

    set_window(6'd1);
    send_sample(in_t'{8'hff, 8'hff, 8'hff});
    send_sample(in_t'{8'h00, 8'h00, 8'h00});
    send_sample(in_t'{8'h81, 8'h7e, 8'hc3});

    // ramp up over a short window
    set_window(6'd4);
    send_sample(in_t'{8'h00, 8'hff, 8'h00});
    send_sample(in_t'{8'hff, 8'h00, 8'h00});
    send_sample(in_t'{8'h00, 8'hff, 8'hff});
    send_sample(in_t'{8'hff, 8'hff, 8'h00});
    send_sample(in_t'{8'h00, 8'h00, 8'hff});
    send_sample(in_t'{8'hff, 8'h00, 8'h80});

    // shrink, then grow past the buffer size
    set_window(6'd2);
    send_sample(in_t'{8'h80, 8'h80, 8'h80});
    send_sample(in_t'{8'h7f, 8'h7f, 8'h7f});
    send_sample(in_t'{8'hff, 8'h00, 8'hff});

    set_window(6'd63);
    repeat (3) send_sample(in_t'{8'hff, 8'hff, 8'hff});
    repeat (3) send_sample(in_t'{8'h00, 8'h00, 8'h00});

    plan = '{6'd32, 6'd0, 6'd7, 6'd40, 6'd1, 6'd63,
             6'd3, 6'd0, 6'd0, 6'd16, 6'd2, 6'd0};
    plan[7]  = 6'($urandom_range(30, 4));
    plan[8]  = 6'($urandom_range(63, 33));
    plan[11] = 6'($urandom_range(63));

    foreach (plan[p]) begin
      set_window(plan[p]);
      no_idle = (p == 4 || p == 5);
      if (p == 2) begin
        run_random(PHASE_ITEMS / 2);
        drain_results();
        run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        run_random(PHASE_ITEMS);
      end
    end
    no_idle = 1'b0;

    drain_results();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("three_axis_moving_average_unit regression: pass");
    end else begin
      $display("three_axis_moving_average_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tama_pkg.sv
hw/rtl/tama_cmd_fifo.sv
hw/rtl/tama_front.sv
hw/rtl/tama_back.sv
hw/rtl/three_axis_moving_average_unit.sv
test/tb.sv
